/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Invariant that holds on every clock edge out of reset
`define ASSERT_ALW(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

`else

`define ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ASSERT_NXT(label, clk, rst_n, ante, cons)
`define ASSERT_ALW(label, clk, rst_n, cond)

`endif

`endif

/* rtl/kvlt_pkg.sv */
// ----------------------------------------------------------------------------
// kvlt_pkg
// Phase codes, result kinds, character constants and the step result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kvlt_pkg;

    localparam int PHASE_W = 4;
    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;

    // Parse phases
    localparam logic [PHASE_W-1:0] PH_BEFORE_KEY = 4'd0;
    localparam logic [PHASE_W-1:0] PH_IN_KEY     = 4'd1;
    localparam logic [PHASE_W-1:0] PH_AFTER_KEY  = 4'd2;
    localparam logic [PHASE_W-1:0] PH_BEFORE_VAL = 4'd3;
    localparam logic [PHASE_W-1:0] PH_IN_VAL     = 4'd4;
    localparam logic [PHASE_W-1:0] PH_IN_SQ      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_IN_DQ      = 4'd6;
    localparam logic [PHASE_W-1:0] PH_AFTER_VAL  = 4'd7;
    localparam logic [PHASE_W-1:0] PH_CMT_NOPAIR = 4'd8;
    localparam logic [PHASE_W-1:0] PH_CMT_PAIR   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_ERROR      = 4'd10;

    // Result kinds
    localparam logic [KIND_W-1:0] K_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] K_KEY    = 3'd1;
    localparam logic [KIND_W-1:0] K_VAL    = 3'd2;
    localparam logic [KIND_W-1:0] K_PAIR   = 3'd3;
    localparam logic [KIND_W-1:0] K_NOPAIR = 3'd4;
    localparam logic [KIND_W-1:0] K_BAD    = 3'd5;
    localparam logic [KIND_W-1:0] K_UNTERM = 3'd6;
    localparam logic [KIND_W-1:0] K_ERREND = 3'd7;

    // Characters with a meaning to the parser
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

    // Outcome of one parse step
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data;
    } t_step;

endpackage

/* rtl/kvlt_step.sv */
// ----------------------------------------------------------------------------
// kvlt_step
// Combinational parse step: next phase, result kind and data byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kvlt_step
    import kvlt_pkg::*;
(
    input  logic [PHASE_W-1:0] i_phase,
    input  logic [BYTE_W-1:0]  i_char,
    input  logic               i_line_end,
    output t_step              o_step
);

    logic is_ws;
    logic is_sep;
    logic is_hash;

    // Classify the character
    assign is_ws   = (i_char == CH_SPACE) || ((i_char >= CH_TAB) && (i_char <= CH_CR));
    assign is_sep  = (i_char == CH_COLON) || (i_char == CH_EQUALS);
    assign is_hash = (i_char == CH_HASH);

    // Advance the phase and form the result
    always_comb begin
        o_step.phase = i_phase;
        o_step.kind  = K_NONE;
        o_step.data  = '0;
        if (i_line_end) begin
            o_step.phase = PH_BEFORE_KEY;
            unique case (i_phase)
                PH_BEFORE_KEY, PH_CMT_NOPAIR: begin
                    o_step.kind = K_NOPAIR;
                end
                PH_BEFORE_VAL, PH_IN_VAL, PH_AFTER_VAL, PH_CMT_PAIR: begin
                    o_step.kind = K_PAIR;
                end
                PH_IN_KEY, PH_AFTER_KEY, PH_IN_SQ, PH_IN_DQ: begin
                    o_step.kind = K_UNTERM;
                end
                default: begin
                    o_step.kind = K_ERREND;
                end
            endcase
        end else begin
            unique case (i_phase)
                PH_BEFORE_KEY: begin
                    if (is_hash) begin
                        o_step.phase = PH_CMT_NOPAIR;
                    end else if (!is_ws) begin
                        o_step.kind  = K_KEY;
                        o_step.data  = i_char;
                        o_step.phase = PH_IN_KEY;
                    end
                end
                PH_IN_KEY: begin
                    if (is_ws) begin
                        o_step.phase = PH_AFTER_KEY;
                    end else if (is_sep) begin
                        o_step.phase = PH_BEFORE_VAL;
                    end else begin
                        o_step.kind = K_KEY;
                        o_step.data = i_char;
                    end
                end
                PH_AFTER_KEY: begin
                    if (is_sep) begin
                        o_step.phase = PH_BEFORE_VAL;
                    end else if (!is_ws) begin
                        o_step.kind  = K_BAD;
                        o_step.phase = PH_ERROR;
                    end
                end
                PH_BEFORE_VAL: begin
                    if (i_char == CH_SQUOTE) begin
                        o_step.phase = PH_IN_SQ;
                    end else if (i_char == CH_DQUOTE) begin
                        o_step.phase = PH_IN_DQ;
                    end else if (!is_ws) begin
                        o_step.kind  = K_VAL;
                        o_step.data  = i_char;
                        o_step.phase = PH_IN_VAL;
                    end
                end
                PH_IN_VAL: begin
                    if (is_ws) begin
                        o_step.phase = PH_AFTER_VAL;
                    end else if (is_hash) begin
                        o_step.phase = PH_CMT_PAIR;
                    end else begin
                        o_step.kind = K_VAL;
                        o_step.data = i_char;
                    end
                end
                PH_IN_SQ: begin
                    if (i_char == CH_SQUOTE) begin
                        o_step.phase = PH_AFTER_VAL;
                    end else begin
                        o_step.kind = K_VAL;
                        o_step.data = i_char;
                    end
                end
                PH_IN_DQ: begin
                    if (i_char == CH_DQUOTE) begin
                        o_step.phase = PH_AFTER_VAL;
                    end else begin
                        o_step.kind = K_VAL;
                        o_step.data = i_char;
                    end
                end
                PH_AFTER_VAL: begin
                    if (is_hash) begin
                        o_step.phase = PH_CMT_PAIR;
                    end else if (!is_ws) begin
                        o_step.kind  = K_BAD;
                        o_step.phase = PH_ERROR;
                    end
                end
                default: begin
                    // comments and errored lines swallow the byte
                    o_step.phase = i_phase;
                end
            endcase
        end
    end

endmodule

/* rtl/key_value_line_tokenizer.sv */
// Pipeline: an accepted item is held in the input register, and its result
// moves into the result register once that register is free to take it.
// Throughput: one item per cycle unless m_axis_tready holds the output; the
// single phase register updates as each item leaves the input register.
// Reset: i_rst_n low at a clock edge empties both register stages and returns
// the parser to the phase before a key.
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// Tokenizes key/value configuration lines into key bytes, value bytes and
// per-line verdicts, one result item for every input item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module key_value_line_tokenizer
    import kvlt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
    input  logic        s_axis_tlast,   // line_end
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] data_byte
    output logic [2:0]  m_axis_tuser    // [2:0] kind
);

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_char;
    logic               r_in_last;
    logic [PHASE_W-1:0] r_phase;
    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [BYTE_W-1:0]  r_out_data;

    logic               out_free;
    logic               advance;
    t_step              n_step;

    // Move the input stage on whenever the result register can take it
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    kvlt_step u_step (
        .i_phase    (r_phase),
        .i_char     (r_in_char),
        .i_line_end (r_in_last),
        .o_step     (n_step)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Phase register and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BEFORE_KEY;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_phase <= n_step.phase;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
        if (advance) begin
            r_out_kind <= n_step.kind;
            r_out_data <= n_step.data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_kind;

    // Phase never leaves the defined codes
    `ASSERT_ALW(a_phase_range, i_clk, i_rst_n, r_phase <= PH_ERROR)
    // A line end returns the parser to the start phase
    `ASSERT_NXT(a_line_end_restart, i_clk, i_rst_n, advance && r_in_last,
                r_phase == PH_BEFORE_KEY)
    // A line end yields a verdict kind
    `ASSERT_NXT(a_line_end_verdict, i_clk, i_rst_n, advance && r_in_last,
                m_axis_tvalid && (m_axis_tuser >= K_PAIR))
    // Only key and value kinds carry a data byte
    `ASSERT_IMP(a_data_zero, i_clk, i_rst_n,
                m_axis_tvalid && !(m_axis_tuser == K_KEY || m_axis_tuser == K_VAL),
                m_axis_tdata == '0)
    // An errored line stays quiet until its end
    `ASSERT_NXT(a_error_quiet, i_clk, i_rst_n,
                advance && (r_phase == PH_ERROR) && !r_in_last,
                m_axis_tuser == K_NONE)

endmodule

/* test/key_value_line_tokenizer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_test
// Drives characters and line ends into the tokenizer and checks every token
// against an in-bench parser. A short directed pass covers the special lines,
// then random lines run with bursts of idling on both sides. Mostly
// well-formed, some broken, some noise.
// ----------------------------------------------------------------------------

module key_value_line_tokenizer_test
    import kvlt_pkg::*;
();

    // One token as the block reports it
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
    } t_token;

    // Whitespace is TAB..CR and space; everything else, 128 and up too, is not
    function automatic bit is_blank(logic [BYTE_W-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Line parser and store of the tokens still to come out of the block
    class token_checker;
        logic [PHASE_W-1:0] phase;
        t_token             expected_tokens[$];
        int                 mismatches;

        function new();
            phase      = PH_BEFORE_KEY;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        // Advance the parser by one accepted item and queue its token
        function void note_char(logic [BYTE_W-1:0] c, logic last);
            t_token t;
            bit     blank;
            bit     sep;
            t.kind = K_NONE;
            t.data = '0;
            blank  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
            sep    = (c == CH_COLON) || (c == CH_EQUALS);
            if (last) begin
                case (phase)
                    PH_BEFORE_KEY, PH_CMT_NOPAIR: t.kind = K_NOPAIR;
                    PH_BEFORE_VAL, PH_IN_VAL, PH_AFTER_VAL, PH_CMT_PAIR: t.kind = K_PAIR;
                    PH_IN_KEY, PH_AFTER_KEY, PH_IN_SQ, PH_IN_DQ: t.kind = K_UNTERM;
                    default: t.kind = K_ERREND;
                endcase
                phase = PH_BEFORE_KEY;
            end else begin
                case (phase)
                    PH_BEFORE_KEY: begin
                        if (c == CH_HASH) begin
                            phase = PH_CMT_NOPAIR;
                        end else if (!blank) begin
                            t.kind = K_KEY;
                            t.data = c;
                            phase  = PH_IN_KEY;
                        end
                    end
                    PH_IN_KEY: begin
                        if (blank) begin
                            phase = PH_AFTER_KEY;
                        end else if (sep) begin
                            phase = PH_BEFORE_VAL;
                        end else begin
                            t.kind = K_KEY;
                            t.data = c;
                        end
                    end
                    PH_AFTER_KEY: begin
                        if (sep) begin
                            phase = PH_BEFORE_VAL;
                        end else if (!blank) begin
                            t.kind = K_BAD;
                            phase  = PH_ERROR;
                        end
                    end
                    PH_BEFORE_VAL: begin
                        if (c == CH_SQUOTE) begin
                            phase = PH_IN_SQ;
                        end else if (c == CH_DQUOTE) begin
                            phase = PH_IN_DQ;
                        end else if (!blank) begin
                            t.kind = K_VAL;
                            t.data = c;
                            phase  = PH_IN_VAL;
                        end
                    end
                    PH_IN_VAL: begin
                        if (blank) begin
                            phase = PH_AFTER_VAL;
                        end else if (c == CH_HASH) begin
                            phase = PH_CMT_PAIR;
                        end else begin
                            t.kind = K_VAL;
                            t.data = c;
                        end
                    end
                    PH_IN_SQ, PH_IN_DQ: begin
                        if ((phase == PH_IN_SQ && c == CH_SQUOTE) ||
                            (phase == PH_IN_DQ && c == CH_DQUOTE)) begin
                            phase = PH_AFTER_VAL;
                        end else begin
                            t.kind = K_VAL;
                            t.data = c;
                        end
                    end
                    PH_AFTER_VAL: begin
                        if (c == CH_HASH) begin
                            phase = PH_CMT_PAIR;
                        end else if (!blank) begin
                            t.kind = K_BAD;
                            phase  = PH_ERROR;
                        end
                    end
                    // comments and errored lines swallow the byte
                    default: ;
                endcase
            end
            expected_tokens.push_back(t);
        endfunction

        // Compare one token from the block with the oldest one queued
        function void check_token(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data);
            t_token t;
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d data %02h", kind, data);
            end else begin
                t = expected_tokens.pop_front();
                if (t.kind !== kind || t.data !== data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: expected kind %0d data %02h, got kind %0d data %02h",
                                 t.kind, t.data, kind, data);
                end
            end
        endfunction
    endclass

    localparam int N_ITEMS     = 600;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 2000;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    token_checker tokens;
    int           items_sent = 0;
    int           tx_rate    = 0;
    int           rx_rate    = 0;
    bit           idle_on    = 1'b1;
    bit           hold_req   = 1'b0;
    int           quiet_cycles = 0;

    key_value_line_tokenizer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] char_byte
        .s_axis_tlast  (s_axis_tlast),   // line_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [7:0] data_byte
        .m_axis_tuser  (m_axis_tuser)    // [2:0] kind
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Note accepted characters and check accepted tokens
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                tokens.note_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                tokens.check_token(m_axis_tuser, m_axis_tdata);
        end
    end

    // Give up when neither side moves an item for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Token sink: random stalls, plus one long hold-off on request
    initial begin : token_sink
        int cyc;
        int gap;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                case ($urandom_range(0, 2))
                    0:       rx_rate = 0;
                    1:       rx_rate = 8;
                    default: rx_rate = 35;
                endcase
            end
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < rx_rate) begin
                gap = $urandom_range(1, 18);
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Offer one item, with an optional gap in front, and wait for acceptance
    task automatic send_item(input logic [7:0] c, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 99) < tx_rate) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b0);
    endtask

    // Hold the input until every queued token has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tokens.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_blank();
        int n;
        n = $urandom_range(0, 5);
        return (n == 5) ? CH_SPACE : CH_TAB + n[7:0];
    endfunction

    function automatic logic [7:0] pick_key_char(bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == CH_COLON || c == CH_EQUALS || (first && c == CH_HASH));
        return c;
    endfunction

    function automatic logic [7:0] pick_bare_char(bit first);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == CH_HASH ||
               (first && (c == CH_SQUOTE || c == CH_DQUOTE)));
        return c;
    endfunction

    function automatic logic [7:0] pick_other_than(logic [7:0] q);
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == q);
        return c;
    endfunction

    function automatic logic [7:0] pick_noise();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 5))
            0:       return CH_HASH;
            1:       return CH_COLON;
            2:       return CH_EQUALS;
            3:       return CH_SQUOTE;
            4:       return CH_DQUOTE;
            default: return pick_blank();
        endcase
    endfunction

    // One random line: mostly key/value pairs, some flawed, some noise
    task automatic send_random_line();
        int         sel;
        int         flaw;
        int         style;
        int         n;
        logic [7:0] q;
        case ($urandom_range(0, 2))
            0:       tx_rate = 0;
            1:       tx_rate = 10;
            default: tx_rate = 40;
        endcase
        sel = $urandom_range(0, 99);
        if (sel < 72) begin
            // flaw: 1 missing separator, 2 unclosed quote, 3 junk after the value
            flaw = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 3) : 0;
            repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
                send_item(pick_key_char(i == 0), 1'b0);
            repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
            if (flaw == 1) begin
                if ($urandom_range(0, 1) == 1)
                    send_item(pick_bare_char(1'b0), 1'b0);
            end else begin
                send_item($urandom_range(0, 1) ? CH_COLON : CH_EQUALS, 1'b0);
                repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
                style = $urandom_range(0, 3);
                n     = $urandom_range(0, 5);
                if (style == 1) begin
                    for (int i = 0; i <= n; i++)
                        send_item(pick_bare_char(i == 0), 1'b0);
                end else if (style >= 2) begin
                    q = (style == 2) ? CH_SQUOTE : CH_DQUOTE;
                    send_item(q, 1'b0);
                    for (int i = 0; i < n; i++)
                        send_item(pick_other_than(q), 1'b0);
                    if (flaw != 2)
                        send_item(q, 1'b0);
                end
                if (flaw != 2) begin
                    repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
                    if (flaw == 3) begin
                        send_item(pick_bare_char(1'b0), 1'b0);
                        repeat ($urandom_range(0, 3))
                            send_item(8'($urandom_range(0, 255)), 1'b0);
                    end else if ($urandom_range(0, 2) == 0) begin
                        send_item(CH_HASH, 1'b0);
                        repeat ($urandom_range(0, 4))
                            send_item(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else if (sel < 84) begin
            // empty or comment-only line
            repeat ($urandom_range(0, 2)) send_item(pick_blank(), 1'b0);
            if ($urandom_range(0, 1) == 1) begin
                send_item(CH_HASH, 1'b0);
                repeat ($urandom_range(0, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            // noise with stray line ends
            repeat ($urandom_range(1, 12))
                send_item(pick_noise(), $urandom_range(0, 9) == 0);
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin : stimulus
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        tokens = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty line, line-end byte ignored
        send_item(8'h5A, 1'b1);
        // comment-only line
        send_text("#");
        send_item(8'h00, 1'b1);
        // key 0x00, spaced separator, hash taken as the first value byte
        send_item(8'h00, 1'b0);
        send_text(" :#");
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        // key without separator
        send_text("k");
        send_item(8'hC3, 1'b1);
        // bad symbol after the key, rest of line swallowed
        send_text("k\tx");
        send_item(8'h81, 1'b1);
        // unclosed single quote
        send_text("a='");
        send_item(8'h7E, 1'b1);
        // empty double-quoted value followed by a comment
        send_text("b=\"\"#");
        send_item(8'h00, 1'b1);
        // empty value
        send_text("a=");
        send_item(8'hA5, 1'b1);
        wait_drained();

        while (items_sent < N_ITEMS) begin
            if (!held && items_sent >= 250) begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && items_sent >= 400) begin
                paused = 1'b1;
                wait_drained();
            end
            idle_on = (items_sent < N_ITEMS - 80);
            send_random_line();
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (tokens.mismatches == 0 && tokens.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* key_value_line_tokenizer.f */
+incdir+rtl
rtl/kvlt_pkg.sv
rtl/kvlt_step.sv
rtl/key_value_line_tokenizer.sv
test/key_value_line_tokenizer_test.sv
